// File: rtl/aca_pkg.sv
// Shared types and constants for the ASID contention allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aca_pkg;

    // Widths of the fixed item fields
    localparam int ASID_W  = 8;
    localparam int COUNT_W = 4;
    localparam int STAT_W  = 2;

    // Widest identifier the cell row can hold (up to 4096 identifiers)
    localparam int ID_MAX_W = 12;

    // Operation codes
    localparam logic OP_OBTAIN = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNALLOCATED = 2'd2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SEL_LIMIT = 1'b0;        // paddr[2] of the limit register
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 4'd10;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic                found;
        logic [COUNT_W-1:0]  best_cnt;
        logic [ID_MAX_W-1:0] best_idx;
        logic [COUNT_W-1:0]  ret_cnt;
    } t_token;

    // Count update broadcast to the row
    typedef struct packed {
        logic                en;
        logic                inc;
        logic [ID_MAX_W-1:0] idx;
    } t_update;

endpackage

// File: rtl/aca_cell.sv
// One cell of the allocator row: holds the share count of one identifier
// and refines the scan token passing through. Depends on aca_pkg.
`timescale 1ns / 1ps

module aca_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [aca_pkg::ID_MAX_W-1:0] i_my_idx,
    input  logic [aca_pkg::COUNT_W-1:0]  i_limit,
    input  logic [aca_pkg::ID_MAX_W-1:0] i_ret_idx,
    input  aca_pkg::t_token              i_tok,
    input  aca_pkg::t_update             i_upd,
    output aca_pkg::t_token              o_tok
);
    import aca_pkg::*;

    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] n_cnt;
    t_token             r_tok;
    t_token             n_tok;
    logic               eligible;

    // Least-shared search: strict less-than keeps the lowest index on ties
    always_comb begin
        eligible = (r_cnt < i_limit) && (!i_tok.found || (r_cnt < i_tok.best_cnt));
        n_tok = i_tok;
        if (eligible) begin
            n_tok.found    = 1'b1;
            n_tok.best_cnt = r_cnt;
            n_tok.best_idx = i_my_idx;
        end
        if (i_my_idx == i_ret_idx) begin
            n_tok.ret_cnt = r_cnt;
        end
    end

    // Count update when this cell is addressed
    always_comb begin
        n_cnt = r_cnt;
        if (i_upd.en && (i_upd.idx == i_my_idx)) begin
            n_cnt = i_upd.inc ? (r_cnt + COUNT_W'(1)) : (r_cnt - COUNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Token register, no reset needed
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/asid_contention_allocator.sv
// Top level of the ASID contention allocator: APB register, sequencer
// and the row of count cells. Depends on aca_pkg and aca_cell.
`timescale 1ns / 1ps

// Usage
// - Command channel: drive i_op / i_asid_index with start; the item is taken
//   at the edge where start is high and busy is low. busy then stays high
//   until the result is produced.
// - Result channel: o_valid pulses for one cycle with o_asid_out,
//   o_flush_needed and o_status. The receiver cannot stall; it must take the
//   result in that cycle.
// - For each item a scan token walks the row of ID_COUNT cells, one cell per
//   cycle, picking up the least-shared identifier and the returned
//   identifier's count; the count update and result register follow.
// - A new start is accepted at the end of the cycle the result is shown, so
//   items do not overlap: the next one is taken only after the last one's result.
// - Configuration: APB write to byte address 0 sets contention_limit;
//   pready is always high. Write only while busy is low.
// - Reset (synchronous, active low): all share counts clear to zero,
//   contention_limit returns to 10, busy and o_valid go low. No clearing
//   pass is needed; the block is ready in the first cycle after reset.

module asid_contention_allocator #(
    parameter int ID_COUNT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [aca_pkg::ASID_W-1:0]   i_asid_index,
    // result channel
    output logic                         o_valid,
    output logic [aca_pkg::ASID_W-1:0]   o_asid_out,
    output logic                         o_flush_needed,
    output logic [aca_pkg::STAT_W-1:0]   o_status,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aca_pkg::PADDR_W-1:0]  paddr,
    input  logic [aca_pkg::PDATA_W-1:0]  pwdata,
    output logic [aca_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import aca_pkg::*;

    localparam int CTR_W = $clog2(ID_COUNT + 1);
    localparam logic [CTR_W-1:0] SCAN_LAST = CTR_W'(ID_COUNT);

    logic [COUNT_W-1:0]  r_limit;
    logic                r_busy;
    logic [CTR_W-1:0]    r_ctr;
    logic                r_op;
    logic [ID_MAX_W-1:0] r_ret_idx;
    logic                r_valid;
    logic [ASID_W-1:0]   r_asid;
    logic                r_flush;
    logic [STAT_W-1:0]   r_status;

    logic                accept;
    logic                finish;
    t_token              tok [0:ID_COUNT];
    t_token              fin_tok;
    t_update             upd;
    logic [ASID_W-1:0]   n_asid;
    logic                n_flush;
    logic [STAT_W-1:0]   n_status;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEL_LIMIT) ? PDATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_SEL_LIMIT)) begin
            r_limit <= pwdata[COUNT_W-1:0];
        end
    end

    // Sequencer: scan along the cell row, then update and result
    assign accept = start && !r_busy;
    assign finish = r_busy && (r_ctr == SCAN_LAST);
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ctr  <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_ctr  <= '0;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_ctr  <= r_ctr + CTR_W'(1);
        end
    end

    // Captured command
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_op;
            r_ret_idx <= ID_MAX_W'(i_asid_index);
        end
    end

    // Cell row; token enters empty at cell 0
    assign tok[0] = '0;

    generate
        for (genvar g = 0; g < ID_COUNT; g++) begin : g_cell
            aca_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_my_idx  (ID_MAX_W'(g)),
                .i_limit   (r_limit),
                .i_ret_idx (r_ret_idx),
                .i_tok     (tok[g]),
                .i_upd     (upd),
                .o_tok     (tok[g+1])
            );
        end
    endgenerate

    assign fin_tok = tok[ID_COUNT];

    // Result and count update from the finished token
    always_comb begin
        upd      = '0;
        n_asid   = '0;
        n_flush  = 1'b0;
        n_status = ST_OK;
        if (r_op == OP_OBTAIN) begin
            if (fin_tok.found) begin
                n_asid  = fin_tok.best_idx[ASID_W-1:0];
                n_flush = (fin_tok.best_cnt != '0);
                upd.en  = finish;
                upd.inc = 1'b1;
                upd.idx = fin_tok.best_idx;
            end else begin
                n_status = ST_EXHAUSTED;
            end
        end else begin
            if (fin_tok.ret_cnt == '0) begin
                n_status = ST_UNALLOCATED;
            end else begin
                upd.en  = finish;
                upd.inc = 1'b0;
                upd.idx = r_ret_idx;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_asid   <= '0;
            r_flush  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_valid <= finish;
            if (finish) begin
                r_asid   <= n_asid;
                r_flush  <= n_flush;
                r_status <= n_status;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_asid_out     = r_asid;
    assign o_flush_needed = r_flush;
    assign o_status       = r_status;

endmodule

// File: rtl/aca_checker.sv
// Port-level checks for the ASID contention allocator, bound to the top.
// Depends on aca_pkg and asid_contention_allocator.
`timescale 1ns / 1ps

module aca_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [aca_pkg::ASID_W-1:0]   o_asid_out,
    input logic                         o_flush_needed,
    input logic [aca_pkg::STAT_W-1:0]   o_status
);
    import aca_pkg::*;

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    // Result strobe only once the item is finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // Strobes are single-cycle pulses
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // Only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_EXHAUSTED ||
                     o_status == ST_UNALLOCATED))
        else $error("undefined status code");

    // Error results carry no identifier and no flush
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_asid_out == '0 && !o_flush_needed))
        else $error("error result carries identifier or flush");

endmodule

bind asid_contention_allocator aca_checker u_aca_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_asid_out     (o_asid_out),
    .o_flush_needed (o_flush_needed),
    .o_status       (o_status)
);

// File: verif/asid_alloc_checker.sv
// Result checker for the ASID contention allocator: keeps its own share counts
// and limit register, predicts the result of every accepted item and compares it.
// Depends on aca_pkg.
`timescale 1ns / 1ps

module asid_alloc_checker #(
    parameter int ID_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_cmd_start,
    input  logic                        i_cmd_busy,
    input  logic                        i_cmd_op,
    input  logic [aca_pkg::ASID_W-1:0]  i_cmd_index,
    // result channel
    input  logic                        i_res_valid,
    input  logic [aca_pkg::ASID_W-1:0]  i_res_asid,
    input  logic                        i_res_flush,
    input  logic [aca_pkg::STAT_W-1:0]  i_res_status,
    // configuration port
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [aca_pkg::PADDR_W-1:0] i_paddr,
    input  logic [aca_pkg::PDATA_W-1:0] i_pwdata,
    input  logic [aca_pkg::PDATA_W-1:0] i_prdata,
    input  logic                        i_pready,
    // to the test top
    output int                          o_fail_count,
    output int                          o_pending
);
    import aca_pkg::*;

    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_SEL_LIMIT, 2'b00};

    typedef struct packed {
        logic [ASID_W-1:0] asid;
        logic              flush;
        logic [STAT_W-1:0] status;
    } t_grant;

    logic [COUNT_W-1:0] share_cnt [ID_COUNT];
    logic [COUNT_W-1:0] limit_cfg;
    t_grant             expected_grants [$];
    int                 fail_count = 0;
    int                 pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    // Work out the grant (or error) for one item and update the share counts
    function automatic t_grant predict_grant(input logic op, input logic [ASID_W-1:0] idx);
        t_grant             g;
        logic               found;
        int                 best;
        logic [COUNT_W-1:0] best_cnt;
        g        = '0;
        found    = 1'b0;
        best     = 0;
        best_cnt = '0;
        if (op == OP_OBTAIN) begin
            // lowest-numbered identifier among the least shared, below the limit
            for (int j = 0; j < ID_COUNT; j++) begin
                if (share_cnt[j] < limit_cfg && (!found || share_cnt[j] < best_cnt)) begin
                    found    = 1'b1;
                    best     = j;
                    best_cnt = share_cnt[j];
                end
            end
            if (found) begin
                g.asid          = best[ASID_W-1:0];
                g.flush         = (best_cnt != '0);
                share_cnt[best] = best_cnt + 1'b1;
            end else begin
                g.status = ST_EXHAUSTED;
            end
        end else begin
            // returning a free or out-of-range identifier leaves counts alone
            if (int'(idx) >= ID_COUNT || share_cnt[idx] == '0) begin
                g.status = ST_UNALLOCATED;
            end else begin
                share_cnt[idx] = share_cnt[idx] - 1'b1;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin : watch_proc
        t_grant want;
        if (!i_rst_n) begin
            foreach (share_cnt[k]) share_cnt[k] = '0;
            limit_cfg = LIMIT_RESET;
            expected_grants.delete();
        end else begin
            // result strobe: compare with the oldest prediction
            if (i_res_valid) begin
                if (expected_grants.size() == 0) begin
                    $error("result with no item outstanding: asid_out %0d status %0d",
                           i_res_asid, i_res_status);
                    fail_count++;
                end else begin
                    want = expected_grants.pop_front();
                    if (i_res_asid !== want.asid) begin
                        $error("asid_out: expected %0d, got %0d", want.asid, i_res_asid);
                        fail_count++;
                    end
                    if (i_res_flush !== want.flush) begin
                        $error("flush_needed: expected %0d, got %0d", want.flush, i_res_flush);
                        fail_count++;
                    end
                    if (i_res_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res_status);
                        fail_count++;
                    end
                end
            end
            // item accepted: predict from the state left by earlier items
            if (i_cmd_start && !i_cmd_busy) begin
                expected_grants.push_back(predict_grant(i_cmd_op, i_cmd_index));
            end
            // register access phase
            if (i_psel && i_penable && i_pready && i_paddr == LIMIT_ADDR) begin
                if (i_pwrite) begin
                    limit_cfg = i_pwdata[COUNT_W-1:0];
                end else if (i_prdata !== PDATA_W'(limit_cfg)) begin
                    $error("contention_limit: expected %0d, got %0d", limit_cfg, i_prdata);
                    fail_count++;
                end
            end
        end
        pending_cnt = expected_grants.size();
    end

endmodule

// File: verif/asid_contention_allocator_test.sv
// Test top for the ASID contention allocator: drives commands and register
// writes, and gives the verdict. Depends on aca_pkg, the block and asid_alloc_checker.
`timescale 1ns / 1ps

module asid_contention_allocator_test;
    import aca_pkg::*;

    localparam int ID_COUNT = 256;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_SEL_LIMIT, 2'b00};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_op;
    logic [ASID_W-1:0]  i_asid_index;
    logic               o_valid;
    logic [ASID_W-1:0]  o_asid_out;
    logic               o_flush_needed;
    logic [STAT_W-1:0]  o_status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 burst_left = 0;

    always #5 i_clk = ~i_clk;

    asid_contention_allocator #(.ID_COUNT(ID_COUNT)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_asid_index   (i_asid_index),
        .o_valid        (o_valid),
        .o_asid_out     (o_asid_out),
        .o_flush_needed (o_flush_needed),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    asid_alloc_checker #(.ID_COUNT(ID_COUNT)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_start  (start),
        .i_cmd_busy   (busy),
        .i_cmd_op     (i_op),
        .i_cmd_index  (i_asid_index),
        .i_res_valid  (o_valid),
        .i_res_asid   (o_asid_out),
        .i_res_flush  (o_flush_needed),
        .i_res_status (o_status),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic op, input logic [ASID_W-1:0] idx);
        int   gap;
        logic wait_ready;
        gap        = 0;
        wait_ready = 1'b0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(4, 16);
            gap        = $urandom_range(0, 4);
            wait_ready = 1'($urandom_range(0, 1));
        end
        if (gap > 0 || wait_ready) begin
            start <= 1'b0;
            // optionally let the block fall idle so the gap lands after busy drops
            if (wait_ready) begin
                do @(negedge i_clk); while (busy);
                @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_op         <= op;
        i_asid_index <= idx;
        do @(posedge i_clk); while (busy);
    endtask

    // Block quiet: nothing outstanding and not busy
    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIMIT_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Change the limit between items, then read it back
    task automatic set_limit(input logic [COUNT_W-1:0] lim);
        wait_idle();
        apb_access(1'b1, PDATA_W'(lim));
        apb_access(1'b0, '0);
    endtask

    // Random items with a given share of obtains
    task automatic run_phase(input logic [COUNT_W-1:0] lim, input int n_items,
                             input int obtain_pct);
        logic op;
        set_limit(lim);
        for (int n = 0; n < n_items; n++) begin
            op = ($urandom_range(1, 100) <= obtain_pct) ? OP_OBTAIN : OP_RETURN;
            send_item(op, ASID_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= OP_OBTAIN;
        i_asid_index <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset limit, returns of free identifiers, first grants
        send_item(OP_RETURN, 8'd0);
        send_item(OP_RETURN, 8'd255);
        send_item(OP_OBTAIN, 8'd255);
        send_item(OP_OBTAIN, 8'd0);
        send_item(OP_OBTAIN, 8'd170);
        send_item(OP_RETURN, 8'd1);
        send_item(OP_OBTAIN, 8'd85);
        send_item(OP_RETURN, 8'd1);
        send_item(OP_RETURN, 8'd1);
        send_item(OP_RETURN, 8'd2);

        // limit of zero: every obtain is exhausted
        set_limit(4'd0);
        send_item(OP_OBTAIN, 8'd0);
        send_item(OP_RETURN, 8'd0);
        send_item(OP_OBTAIN, 8'd255);

        // widest limit, then back to the reset value
        set_limit(4'd15);
        send_item(OP_OBTAIN, 8'd0);
        send_item(OP_OBTAIN, 8'd0);
        send_item(OP_RETURN, 8'd0);
        send_item(OP_OBTAIN, 8'd0);
        set_limit(4'd10);
        send_item(OP_OBTAIN, 8'd0);
        send_item(OP_RETURN, 8'd255);

        // Random: fill every identifier at limit one until exhaustion
        run_phase(4'd1, 290, 97);
        // raise to the top: identifiers already in use can be granted again, with a flush
        run_phase(4'd15, 70, 75);
        // lower again: counts above the new limit are kept
        run_phase(4'd2, 50, 40);
        run_phase(4'($urandom_range(3, 14)), 40, 60);

        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (ID_COUNT + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
